// ===== rtl/packed_pixel_unpacker_core_defines.svh =====
// Assertion macros used by the checker file of the packed pixel unpacker.
// No dependencies; the including module must have clk and rst_n in scope.
`ifndef PACKED_PIXEL_UNPACKER_CORE_DEFINES_SVH
`define PACKED_PIXEL_UNPACKER_CORE_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define PPU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PPU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ppu_pkg.sv =====
// Types and constants of the packed pixel unpacker.
// No dependencies; used by the top level, ppu_unpack and ppu_out_queue.
`default_nettype none

package ppu_pkg;

    localparam int BYTE_W  = 8;
    localparam int PIXEL_W = 12;
    localparam int REG_W   = 10;
    localparam int PAIR_W  = 9;
    localparam int ROW_W   = 10;

    // Position of the next byte inside its three-byte group.
    localparam logic [1:0] PHASE_FIRST  = 2'd0;
    localparam logic [1:0] PHASE_SECOND = 2'd1;
    localparam logic [1:0] PHASE_THIRD  = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_ROW_WIDTH = 1'b0;
    localparam logic CFG_ROW_COUNT = 1'b1;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic               is_padding;
        logic               row_end;
        logic               frame_end;
    } result_t;

    // Results caused by one byte: count is 0, 1 or 2, first result in r0.
    typedef struct packed {
        logic [1:0] count;
        result_t    r0;
        result_t    r1;
    } unpack_out_t;

endpackage

`default_nettype wire

// ===== rtl/packed_pixel_unpacker_core.sv =====
// Top level of the packed 12-bit pixel unpacker: configuration registers,
// unpack logic and output queue. Depends on ppu_pkg, ppu_unpack, ppu_out_queue.
//
//   channel   direction  handshake              payload
//   s_*       in         s_tvalid / s_tready    port_byte
//   m_*       out        m_tvalid / m_tready    pixel, is_padding, row_end, frame_end
//   cfg_*     in         cfg_we                 row_width, row_count
//
// One byte is taken per cycle while s_tready is high; its results enter the
// output queue at the accepting edge, show on m_* from the next cycle and leave
// one per cycle. The third byte of an odd row's last pair makes two results;
// the four-entry queue absorbs them and s_tready drops while it holds three or
// four results. Reset restores row_width 650, row_count 490 and starts a new
// frame. A stall on m_tready only backs up into s_tready through the queue fill.
`default_nettype none

module packed_pixel_unpacker_core #(
    parameter int MAX_WIDTH = 1024,
    parameter int MAX_ROWS  = 1024
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] port_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [11:0] pixel, [15:12] zero
    output logic [1:0]       m_tuser,   // [0] is_padding, [1] row_end
    output logic             m_tlast,   // frame_end
    input  wire logic        cfg_we,
    input  wire logic        cfg_addr,
    input  wire logic [9:0]  cfg_wdata
);
    import ppu_pkg::*;

    logic [REG_W-1:0] width_reg;
    logic [REG_W-1:0] count_reg;
    logic             accept;
    unpack_out_t      results;
    result_t          head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= REG_W'(650);
            count_reg <= REG_W'(490);
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_ROW_WIDTH: width_reg <= cfg_wdata;
                CFG_ROW_COUNT: count_reg <= cfg_wdata;
                default:       width_reg <= width_reg;
            endcase
        end
    end

    assign accept = s_tvalid && s_tready;

    ppu_unpack #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_ROWS  (MAX_ROWS)
    ) u_unpack (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .in_byte   (s_tdata),
        .row_width (width_reg),
        .row_count (count_reg),
        .results   (results)
    );

    ppu_out_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept),
        .push_data  (results),
        .room       (s_tready),
        .head_valid (m_tvalid),
        .head       (head),
        .pop_ready  (m_tready)
    );

    assign m_tdata = {4'd0, head.pixel};
    assign m_tuser = {head.row_end, head.is_padding};
    assign m_tlast = head.frame_end;

endmodule

`default_nettype wire

// ===== rtl/ppu_unpack.sv =====
// Byte phase tracking, pixel assembly and row/frame counters.
// Depends on ppu_pkg.
`default_nettype none

module ppu_unpack #(
    parameter int MAX_WIDTH = 1024,
    parameter int MAX_ROWS  = 1024
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      accept,
    input  wire logic [ppu_pkg::BYTE_W-1:0] in_byte,
    input  wire logic [ppu_pkg::REG_W-1:0]  row_width,
    input  wire logic [ppu_pkg::REG_W-1:0]  row_count,
    output ppu_pkg::unpack_out_t            results
);
    import ppu_pkg::*;

    logic [1:0]         phase_reg, phase_next;
    logic [PIXEL_W-1:0] partial_reg, partial_next;
    logic [PAIR_W-1:0]  pair_reg, pair_next;
    logic [ROW_W-1:0]   row_reg, row_next;

    logic [REG_W-1:0]   w_lim;
    logic [REG_W-1:0]   h_lim;
    logic [PAIR_W-1:0]  pairs;
    logic               odd;
    logic               last_pair;
    logic               last_row;
    logic               end_here;

    // Clamp the registers to the supported frame size; a zero row or pair count counts as one.
    always_comb
    begin
        if (13'(row_width) > 13'(MAX_WIDTH))
            w_lim = REG_W'(MAX_WIDTH);
        else
            w_lim = row_width;
        if (13'(row_count) > 13'(MAX_ROWS))
            h_lim = REG_W'(MAX_ROWS);
        else
            h_lim = row_count;
        if (h_lim == '0)
            h_lim = REG_W'(1);
        pairs = w_lim[REG_W-1:1];
        if (pairs == '0)
            pairs = PAIR_W'(1);
        odd = w_lim[0];
    end

    // An index at or past the last one counts as last, so a mid-frame
    // register change still closes the row or frame.
    assign last_pair = ({1'b0, pair_reg} + (PAIR_W+1)'(1)) >= {1'b0, pairs};
    assign last_row  = ({1'b0, row_reg} + (ROW_W+1)'(1)) >= {1'b0, h_lim};
    assign end_here  = last_pair && !odd;

    always_comb
    begin
        phase_next   = phase_reg;
        partial_next = partial_reg;
        pair_next    = pair_reg;
        row_next     = row_reg;
        results      = '0;
        case (phase_reg)
            PHASE_SECOND:
            begin
                results.count    = 2'd1;
                results.r0.pixel = {partial_reg[11:4], in_byte[7:4]};
                partial_next     = {in_byte[3:0], 8'd0};
                phase_next       = PHASE_THIRD;
            end
            PHASE_THIRD:
            begin
                results.count        = 2'd1;
                results.r0.pixel     = {partial_reg[11:8], in_byte};
                results.r0.row_end   = end_here;
                results.r0.frame_end = end_here && last_row;
                if (last_pair && odd)
                begin
                    results.count         = 2'd2;
                    results.r1.is_padding = 1'b1;
                    results.r1.row_end    = 1'b1;
                    results.r1.frame_end  = last_row;
                end
                partial_next = '0;
                phase_next   = PHASE_FIRST;
                if (last_pair)
                begin
                    pair_next = '0;
                    row_next  = last_row ? '0 : row_reg + ROW_W'(1);
                end
                else
                begin
                    pair_next = pair_reg + PAIR_W'(1);
                end
            end
            default:
            begin
                partial_next = {in_byte, 4'd0};
                phase_next   = PHASE_SECOND;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PHASE_FIRST;
            partial_reg <= '0;
            pair_reg    <= '0;
            row_reg     <= '0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            partial_reg <= partial_next;
            pair_reg    <= pair_next;
            row_reg     <= row_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ppu_out_queue.sv =====
// Four-entry result queue between the unpack logic and the output channel.
// Depends on ppu_pkg.
`default_nettype none

module ppu_out_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire ppu_pkg::unpack_out_t push_data,
    output logic                      room,
    output logic                      head_valid,
    output ppu_pkg::result_t          head,
    input  wire logic                 pop_ready
);
    import ppu_pkg::*;

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    result_t          mem [DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next;
    logic [PTR_W-1:0] rd_reg, rd_next;
    logic [PTR_W:0]   cnt_reg, cnt_next;
    logic [1:0]       push_n;
    logic             pop;

    assign push_n     = push ? push_data.count : 2'd0;
    assign head_valid = (cnt_reg != '0);
    assign head       = mem[rd_reg];
    assign pop        = head_valid && pop_ready;
    // Room for the two results of a padded row end, decided from registers only.
    assign room       = (cnt_reg <= (PTR_W+1)'(DEPTH - 2));

    assign wr_next  = wr_reg + PTR_W'(push_n);
    assign rd_next  = rd_reg + PTR_W'(pop);
    assign cnt_next = cnt_reg + (PTR_W+1)'(push_n) - (PTR_W+1)'(pop);

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
            mem[wr_reg] <= push_data.r0;
        if (push_n == 2'd2)
            mem[wr_reg + PTR_W'(1)] <= push_data.r1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ppu_checker.sv =====
// Port-level checks of the packed pixel unpacker, bound to the top level.
// Depends on packed_pixel_unpacker_core_defines.svh.
`default_nettype none

`include "packed_pixel_unpacker_core_defines.svh"

module ppu_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic [1:0]  m_tuser,
    input wire logic        m_tlast
);

    // A stalled result item keeps its payload.
    `PPU_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "result item changed while stalled")

    // Padding is a zero pixel that always closes its row.
    `PPU_ASSERT_NOW(a_pad_zero, m_tvalid && m_tuser[0], m_tdata == 16'd0 && m_tuser[1], "padding item not a zero row end")

    // The end of a frame is also the end of a row.
    `PPU_ASSERT_NOW(a_frame_row, m_tvalid && m_tlast, m_tuser[1], "frame end without row end")

    // Only twelve pixel bits are ever set.
    `PPU_ASSERT_NOW(a_pix_range, m_tvalid, m_tdata[15:12] == 4'd0, "pixel above twelve bits")

endmodule

bind packed_pixel_unpacker_core ppu_checker u_ppu_checker (.*);

`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking bench for packed_pixel_unpacker_core: bytes go in, 12-bit pixels come out.
// Depends on ppu_pkg and the core; predicts every pixel and flag, compares in order.
`timescale 1ns / 100ps

module tb;
    import ppu_pkg::*;

    localparam int MAX_W       = 1024;
    localparam int MAX_H       = 1024;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 4;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_we;
    logic        cfg_addr;
    logic [9:0]  cfg_wdata;

    // Predictor state, a private copy of what the block should hold.
    logic [9:0]  cfg_width;
    logic [9:0]  cfg_rows;
    logic [1:0]  grp_phase;
    logic [11:0] held_bits;
    logic [8:0]  pair_pos;
    logic [9:0]  row_pos;

    result_t     pixel_expect[$];
    int          mismatch_count;
    int          tx_idle_pct;
    int          rx_idle_pct;
    int          stall_left;

    packed_pixel_unpacker_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic result_t make_pixel(input logic [11:0] pix, input logic pad,
                                           input logic re, input logic fe);
        result_t r;
        r.pixel      = pix;
        r.is_padding = pad;
        r.row_end    = re;
        r.frame_end  = fe;
        return r;
    endfunction

    // Works out the pixels that one accepted byte causes and queues them.
    task automatic unpack_byte(input logic [7:0] b);
        int   w;
        int   h;
        int   pairs;
        logic odd;
        logic last_pair;
        logic last_row;
        logic end_here;
        w = cfg_width;
        h = cfg_rows;
        if (w > MAX_W)
            w = MAX_W;
        if (h > MAX_H)
            h = MAX_H;
        if (h == 0)
            h = 1;
        pairs = w >> 1;
        if (pairs == 0)
            pairs = 1;
        odd       = w[0];
        last_pair = (int'(pair_pos) + 1) >= pairs;
        last_row  = (int'(row_pos) + 1) >= h;

        if (grp_phase == PHASE_SECOND)
        begin
            pixel_expect.push_back(make_pixel({held_bits[11:4], b[7:4]}, 1'b0, 1'b0, 1'b0));
            held_bits = {b[3:0], 8'h00};
            grp_phase = PHASE_THIRD;
        end
        else if (grp_phase == PHASE_THIRD)
        begin
            end_here = last_pair && !odd;
            pixel_expect.push_back(make_pixel({held_bits[11:8], b}, 1'b0, end_here,
                                              end_here && last_row));
            if (last_pair && odd)
                pixel_expect.push_back(make_pixel(12'h000, 1'b1, 1'b1, last_row));
            held_bits = 12'h000;
            grp_phase = PHASE_FIRST;
            if (last_pair)
            begin
                pair_pos = '0;
                row_pos  = last_row ? 10'd0 : row_pos + 10'd1;
            end
            else
                pair_pos = pair_pos + 9'd1;
        end
        else
        begin
            // The unused fourth phase value behaves like the first byte of a group.
            held_bits = {b, 4'h0};
            grp_phase = PHASE_SECOND;
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch: %s got %0h expected %0h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    task automatic check_pixel();
        result_t want;
        if (pixel_expect.size() == 0)
        begin
            report_mismatch("unexpected pixel", m_tdata, 0);
        end
        else
        begin
            want = pixel_expect.pop_front();
            if (m_tdata[11:0] !== want.pixel)
                report_mismatch("pixel", m_tdata[11:0], want.pixel);
            if (m_tdata[15:12] !== 4'h0)
                report_mismatch("tdata fill", m_tdata[15:12], 0);
            if (m_tuser[0] !== want.is_padding)
                report_mismatch("is_padding", m_tuser[0], want.is_padding);
            if (m_tuser[1] !== want.row_end)
                report_mismatch("row_end", m_tuser[1], want.row_end);
            if (m_tlast !== want.frame_end)
                report_mismatch("frame_end", m_tlast, want.frame_end);
        end
    endtask

    // Pixel sink: checks each accepted item and decides tready for the next edge.
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                check_pixel();
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Ends the run when no item moves on either side for too long.
    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!s_tready);
        unpack_byte(b);
    endtask

    // Stops the sender and waits until every predicted pixel has come out.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pixel_expect.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic program_geometry(input logic [9:0] w, input logic [9:0] h);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_ROW_WIDTH;
        cfg_wdata <= w;
        @(posedge clk);
        cfg_width = w;
        cfg_addr  <= CFG_ROW_COUNT;
        cfg_wdata <= h;
        @(posedge clk);
        cfg_rows = h;
        cfg_we   <= 1'b0;
    endtask

    function automatic logic [7:0] random_byte();
        case ($urandom_range(9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Bit patterns at the reset geometry, then a width change in the middle of a frame,
    // a zero row count, and the widths below two.
    task automatic test_directed();
        logic [7:0] pattern[6];
        pattern = '{8'h00, 8'hFF, 8'hF0, 8'h0F, 8'hA5, 8'h5A};
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        foreach (pattern[i])
            send_byte(pattern[i]);
        program_geometry(10'd3, 10'd0);
        foreach (pattern[i])
            send_byte(pattern[5 - i]);
        program_geometry(10'd1, 10'd1);
        repeat (3) send_byte(random_byte());
        program_geometry(10'd0, 10'd2);
        repeat (6) send_byte(random_byte());
    endtask

    // Mostly small frames so that row and frame ends come often; the extremes now and then.
    task automatic test_random_frames(input int n_bytes, input int tx_pct, input int rx_pct);
        int sent;
        int burst;
        sent = 0;
        while (sent < n_bytes)
        begin
            case ($urandom_range(11))
                0:       program_geometry(10'd2, 10'd1);
                1:       program_geometry(10'd1023, 10'd1023);
                2:       program_geometry(10'($urandom_range(1)), 10'($urandom_range(3)));
                3:       program_geometry(10'd1023, 10'd1);
                default: program_geometry(10'($urandom_range(16, 2)),
                                          10'($urandom_range(4, 1)));
            endcase
            tx_idle_pct = tx_pct;
            rx_idle_pct = rx_pct;
            burst = $urandom_range(120, 30);
            repeat (burst) send_byte(random_byte());
            sent += burst;
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
    endtask

    // The sink holds off for a long time while bytes keep coming, so the queue fills.
    task automatic test_output_stall();
        program_geometry(10'd5, 10'd3);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        stall_left  = 400;
        repeat (60) send_byte(random_byte());
    endtask

    initial
    begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = 8'h00;
        cfg_we         = 1'b0;
        cfg_addr       = CFG_ROW_WIDTH;
        cfg_wdata      = 10'd0;
        mismatch_count = 0;
        tx_idle_pct    = 0;
        rx_idle_pct    = 0;
        stall_left     = 0;
        cfg_width      = 10'd650;
        cfg_rows       = 10'd490;
        grp_phase      = PHASE_FIRST;
        held_bits      = 12'h000;
        pair_pos       = '0;
        row_pos        = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_frames(550, 24, 67);
        test_random_frames(550, 67, 24);
        test_random_frames(550, 0, 0);
        test_output_stall();

        wait_drained();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && pixel_expect.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
